// File: rtl/translated_block_cache_top_assert.svh
// Assertion macros for the translated block cache.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TRANSLATED_BLOCK_CACHE_TOP_ASSERT_SVH
`define TRANSLATED_BLOCK_CACHE_TOP_ASSERT_SVH

// checked only out of reset
`define TBC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TBC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tbc_pkg.sv
// Shared types, codes and helpers of the translated block cache.
// No dependencies.
`default_nettype none

package tbc_pkg;

  localparam int SLOT_W = 8;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef enum logic [2:0] {
    KIND_HIT      = 3'd0,
    KIND_MISS     = 3'd1,
    KIND_INS_OK   = 3'd2,
    KIND_TOO_BIG  = 3'd3,
    KIND_FULL     = 3'd4
  } kind_t;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [7:0]  data_byte;
    logic [7:0]  arch_tag;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [6:0]  block_size;
    logic [31:0] entry_hits;
    logic [7:0]  stored_arch;
    logic [6:0]  hit_percent;
    logic        run_last;
  } out_item_t;

  // what a cell hands to the next one down the row
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [6:0]        size;
    logic [7:0]        arch;
    logic [31:0]       hits;
  } cell_link_t;

  // broadcast control into the row
  typedef struct packed {
    logic              wr;
    logic              wr_new;
    logic              bump;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       key;
    logic [6:0]        size;
    logic [7:0]        arch;
  } cell_ctl_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tbc_cell.sv
// One cache entry: key, size, tag and hit count, plus its link in the match row.
// Depends on tbc_pkg.
`default_nettype none

module tbc_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               filled,
  input  wire logic [31:0]        cmp_key,
  input  wire tbc_pkg::cell_ctl_t ctl,
  input  wire tbc_pkg::cell_link_t link_in,
  output tbc_pkg::cell_link_t     link_out
);

  logic [31:0] key_r;
  logic [6:0]  size_r;
  logic [7:0]  arch_r;
  logic [31:0] hits_r;
  logic        sel;
  logic        first;

  assign sel   = (ctl.slot == tbc_pkg::SLOT_W'(IDX));
  // first filled match in slot order wins
  assign first = filled && (key_r == cmp_key) && !link_in.found;

  always_comb begin
    if (first) begin
      link_out.found = 1'b1;
      link_out.slot  = tbc_pkg::SLOT_W'(IDX);
      link_out.size  = size_r;
      link_out.arch  = arch_r;
      link_out.hits  = hits_r;
    end else begin
      link_out = link_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      key_r  <= ctl.key;
      size_r <= ctl.size;
      arch_r <= ctl.arch;
    end
    if (ctl.wr && ctl.wr_new && sel) begin
      hits_r <= 32'd0;
    end else if (ctl.bump && sel) begin
      hits_r <= tbc_pkg::sat_inc(hits_r);
    end
  end

endmodule

`default_nettype wire

// File: rtl/tbc_pct_div.sv
// Hit percentage unit: hits*100/(hits+misses), one quotient bit per cycle.
// Depends on nothing beyond the clock and reset.
`default_nettype none

module tbc_pct_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] hits,
  input  wire logic [31:0] misses,
  output logic             done,
  output logic [6:0]       pct
);

  logic        act_r,  act_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  b_r,    b_nxt;
  logic [38:0] rem_r,  rem_nxt;
  logic [32:0] den_r,  den_nxt;
  logic [6:0]  q_r,    q_nxt;
  logic        zero_r, zero_nxt;
  logic [38:0] trial;

  assign trial = 39'(den_r) << b_r;

  always_comb begin
    act_nxt  = act_r;
    done_nxt = 1'b0;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    if (start) begin
      // times 100 = 64 + 32 + 4
      rem_nxt  = (39'(hits) << 6) + (39'(hits) << 5) + (39'(hits) << 2);
      den_nxt  = 33'(hits) + 33'(misses);
      zero_nxt = (hits == 32'd0) && (misses == 32'd0);
      b_nxt    = 3'd6;
      q_nxt    = 7'd0;
      act_nxt  = 1'b1;
    end else if (act_r) begin
      if (rem_r >= trial) begin
        rem_nxt    = rem_r - trial;
        q_nxt[b_r] = 1'b1;
      end
      if (b_r == 3'd0) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        b_nxt = b_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
    end
    b_r    <= b_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign pct  = zero_r ? 7'd0 : q_r;

endmodule

`default_nettype wire

// File: rtl/translated_block_cache_top.sv
// Translated block cache: a row of entry cells, a byte store with one region per slot
// and a staging buffer. Miss: result after the lookup state and the 7-step divide, next
// beat taken then. Hit of N bytes: after the divide, N beats, one a cycle; next beat taken
// with the last. Insert bytes before the last: no result. Last byte of N bytes: result after
// the compare, copy and finish states (from the compare if rejected); next beat taken then.
// Synchronous active-low reset empties the table and counters; results cannot stall.
`default_nettype none

module translated_block_cache_top #(
  parameter int MAX_ENTRIES = 32,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tbc_pkg::in_item_t in_item,
  output logic                   out_valid,
  output tbc_pkg::out_item_t     out_item
);

  localparam int SW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH = MAX_ENTRIES * BLOCK_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW    = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LKUP   = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_STREAM = 7'b0001000,
    ST_ICMP   = 7'b0010000,
    ST_COPY   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t              state_r,    state_nxt;
  logic [CW-1:0]       cnt_r,      cnt_nxt;     // filled entries
  logic [6:0]          scnt_r,     scnt_nxt;    // staged bytes
  logic                sovf_r,     sovf_nxt;
  logic [31:0]         hit_tot_r,  hit_tot_nxt;
  logic [31:0]         miss_tot_r, miss_tot_nxt;
  logic [6:0]          pct_r,      pct_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                last_r,     last_nxt;
  logic                div_go_r,   div_go_nxt;
  logic                cp_v_r,     cp_v_nxt;
  logic [AW-1:0]       cp_addr_r,  cp_addr_nxt;
  logic [31:0]         key_r,      key_nxt;
  logic [7:0]          arch_in_r,  arch_in_nxt;
  logic [SW-1:0]       slot_r,     slot_nxt;
  logic [6:0]          size_r,     size_nxt;
  logic [7:0]          arch_r,     arch_nxt;
  logic [31:0]         ehits_r,    ehits_nxt;
  logic [6:0]          k_r,        k_nxt;
  logic                ins_new_r,  ins_new_nxt;
  tbc_pkg::kind_t      kind_r,     kind_nxt;

  logic                accept;
  logic                stg_we;
  logic [AW-1:0]       base;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          stg_rdata_r;
  logic [7:0]          st_rdata_r;
  logic                div_done;
  logic [6:0]          div_pct;
  logic                is_hit;

  logic [7:0]          stg_mem [BLOCK_BYTES];
  logic [7:0]          st_mem  [DEPTH];

  tbc_pkg::cell_ctl_t  ctl;
  tbc_pkg::cell_link_t link [MAX_ENTRIES + 1];
  tbc_pkg::cell_link_t link_end;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // --- entry row: key broadcast, first match travels down the links ---
  assign link[0]  = '0;
  assign link_end = link[MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    tbc_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .filled   (cnt_r > CW'(i)),
      .cmp_key  (key_r),
      .ctl      (ctl),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  always_comb begin
    ctl.wr     = (state_r == ST_FINISH);
    ctl.wr_new = ins_new_r;
    ctl.bump   = (state_r == ST_LKUP) && link_end.found;
    ctl.slot   = ctl.bump ? link_end.slot : tbc_pkg::SLOT_W'(slot_r);
    ctl.key    = key_r;
    ctl.size   = scnt_r;
    ctl.arch   = arch_in_r;
  end

  // --- percentage unit, run once per lookup on the updated totals ---
  tbc_pct_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_go_r),
    .hits   (hit_tot_r),
    .misses (miss_tot_r),
    .done   (div_done),
    .pct    (div_pct)
  );

  // slot region base in the byte store
  assign base    = AW'(slot_r) * AW'(BLOCK_BYTES);
  assign rd_addr = base + AW'(k_r);

  // --- control ---
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scnt_nxt      = scnt_r;
    sovf_nxt      = sovf_r;
    hit_tot_nxt   = hit_tot_r;
    miss_tot_nxt  = miss_tot_r;
    pct_nxt       = pct_r;
    out_valid_nxt = 1'b0;
    last_nxt      = last_r;
    div_go_nxt    = 1'b0;
    cp_v_nxt      = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    key_nxt       = key_r;
    arch_in_nxt   = arch_in_r;
    slot_nxt      = slot_r;
    size_nxt      = size_r;
    arch_nxt      = arch_r;
    ehits_nxt     = ehits_r;
    k_nxt         = k_r;
    ins_new_nxt   = ins_new_r;
    kind_nxt      = kind_r;
    stg_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt = in_item.key;
          if (in_item.func == tbc_pkg::FUNC_LOOKUP) begin
            state_nxt = ST_LKUP;
          end else begin
            if (scnt_r < 7'(BLOCK_BYTES)) begin
              stg_we   = 1'b1;
              scnt_nxt = scnt_r + 7'd1;
            end else begin
              sovf_nxt = 1'b1;
            end
            if (in_item.last_byte) begin
              arch_in_nxt = in_item.arch_tag;
              state_nxt   = ST_ICMP;
            end
          end
        end
      end
      ST_LKUP: begin
        if (link_end.found) begin
          slot_nxt    = link_end.slot[SW-1:0];
          size_nxt    = link_end.size;
          arch_nxt    = link_end.arch;
          ehits_nxt   = tbc_pkg::sat_inc(link_end.hits);
          hit_tot_nxt = tbc_pkg::sat_inc(hit_tot_r);
          kind_nxt    = tbc_pkg::KIND_HIT;
        end else begin
          miss_tot_nxt = tbc_pkg::sat_inc(miss_tot_r);
          kind_nxt     = tbc_pkg::KIND_MISS;
        end
        div_go_nxt = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          pct_nxt = div_pct;
          if (kind_r == tbc_pkg::KIND_HIT) begin
            k_nxt     = 7'd0;
            state_nxt = ST_STREAM;
          end else begin
            out_valid_nxt = 1'b1;
            last_nxt      = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_STREAM: begin
        // read issued now, beat shown next cycle with the registered data
        out_valid_nxt = 1'b1;
        last_nxt      = (k_r == size_r - 7'd1);
        k_nxt         = k_r + 7'd1;
        if (k_r == size_r - 7'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ICMP: begin
        if (sovf_r || (scnt_r == 7'd0)) begin
          kind_nxt      = tbc_pkg::KIND_TOO_BIG;
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          scnt_nxt      = 7'd0;
          sovf_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!link_end.found && (cnt_r >= CW'(MAX_ENTRIES))) begin
          kind_nxt      = tbc_pkg::KIND_FULL;
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          scnt_nxt      = 7'd0;
          sovf_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          slot_nxt    = link_end.found ? link_end.slot[SW-1:0] : cnt_r[SW-1:0];
          ins_new_nxt = !link_end.found;
          k_nxt       = 7'd0;
          state_nxt   = ST_COPY;
        end
      end
      ST_COPY: begin
        cp_v_nxt    = 1'b1;
        cp_addr_nxt = base + AW'(k_r);
        k_nxt       = k_r + 7'd1;
        if (k_r == scnt_r - 7'd1) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // last store write lands this cycle, entry fields written alongside
        if (ins_new_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        kind_nxt      = tbc_pkg::KIND_INS_OK;
        out_valid_nxt = 1'b1;
        last_nxt      = 1'b1;
        scnt_nxt      = 7'd0;
        sovf_nxt      = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      scnt_r      <= 7'd0;
      sovf_r      <= 1'b0;
      hit_tot_r   <= 32'd0;
      miss_tot_r  <= 32'd0;
      pct_r       <= 7'd0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      cp_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scnt_r      <= scnt_nxt;
      sovf_r      <= sovf_nxt;
      hit_tot_r   <= hit_tot_nxt;
      miss_tot_r  <= miss_tot_nxt;
      pct_r       <= pct_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= div_go_nxt;
      cp_v_r      <= cp_v_nxt;
    end
    last_r    <= last_nxt;
    cp_addr_r <= cp_addr_nxt;
    key_r     <= key_nxt;
    arch_in_r <= arch_in_nxt;
    slot_r    <= slot_nxt;
    size_r    <= size_nxt;
    arch_r    <= arch_nxt;
    ehits_r   <= ehits_nxt;
    k_r       <= k_nxt;
    ins_new_r <= ins_new_nxt;
    kind_r    <= kind_nxt;
  end

  // --- staging buffer ---
  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[scnt_r[GW-1:0]] <= in_item.data_byte;
    end
    stg_rdata_r <= stg_mem[k_r[GW-1:0]];
  end

  // --- block store, one write and one read port ---
  always_ff @(posedge clk) begin
    if (cp_v_r) begin
      st_mem[cp_addr_r] <= stg_rdata_r;
    end
    st_rdata_r <= st_mem[rd_addr];
  end

  // --- result beat ---
  assign is_hit = (kind_r == tbc_pkg::KIND_HIT);

  always_comb begin
    out_item.kind        = kind_r;
    out_item.out_byte    = is_hit ? st_rdata_r : 8'd0;
    out_item.block_size  = is_hit ? size_r : 7'd0;
    out_item.entry_hits  = is_hit ? ehits_r : 32'd0;
    out_item.stored_arch = is_hit ? arch_r : 8'd0;
    out_item.hit_percent = pct_r;
    out_item.run_last    = last_r;
  end

  assign out_valid = out_valid_r;

  `include "translated_block_cache_top_assert.svh"

  `TBC_ASSERT_CLK(a_no_beat_after_accept, (start && !busy) |=> !out_valid, "beat right after accept")
  `TBC_ASSERT_CLK(a_cnt_bound, cnt_r <= CW'(MAX_ENTRIES), "entry count past table size")
  `TBC_ASSERT_CLK(a_single_non_hit, (out_valid && !is_hit) |-> out_item.run_last, "non-hit not last")
  `TBC_ASSERT_ANY(a_quiet_after_reset, !rst_n |=> !out_valid, "beat after reset")

endmodule

`default_nettype wire

// File: dv/translated_block_cache_top_tb.sv
// Self-checking testbench for translated_block_cache_top: directed table, then random
// lookups and insert byte streams, each result checked against an in-bench cache predictor.
// Depends on tbc_pkg (item structs, result kinds, function codes) and the top level.
`default_nettype none

module translated_block_cache_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 32;
  localparam int BLK_BYTES   = 64;
  localparam int RAND_BEATS  = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;   // well past any result latency

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  tbc_pkg::in_item_t  in_item;
  logic               out_valid;
  tbc_pkg::out_item_t out_item;

  translated_block_cache_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Cache predictor: a private copy of the table, store, staging and counters.
  // ---------------------------------------------------------------------------
  logic [31:0] cache_key   [SLOTS];
  logic [6:0]  cache_size  [SLOTS];
  logic [7:0]  cache_arch  [SLOTS];
  logic [31:0] cache_hits  [SLOTS];
  logic [7:0]  cache_bytes [SLOTS*BLK_BYTES];
  logic [7:0]  stage_buf   [BLK_BYTES];
  int          slots_used;
  int          stage_len;
  bit          stage_ovf;
  logic [31:0] lookup_hits;
  logic [31:0] lookup_misses;

  tbc_pkg::out_item_t results_due[$];   // expected results, oldest first
  int          n_pushed;                // expected results ever queued
  int          mismatches;
  int          cycles;
  bit          idle_en;

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [6:0] hit_pct();
    logic [63:0] total;
    total = {32'd0, lookup_hits} + {32'd0, lookup_misses};
    if (total == 0) return 7'd0;
    return 7'(({32'd0, lookup_hits} * 64'd100) / total);
  endfunction

  function automatic int slot_of(input logic [31:0] k);
    for (int i = 0; i < slots_used; i++)
      if (cache_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void push_status(input tbc_pkg::kind_t kd);
    tbc_pkg::out_item_t r;
    r = '0;
    r.kind        = kd;
    r.hit_percent = hit_pct();
    r.run_last    = 1'b1;
    results_due.push_back(r);
    n_pushed++;
  endfunction

  function automatic void predict_cache(input tbc_pkg::in_item_t it);
    int                 s;
    int                 n;
    tbc_pkg::out_item_t r;
    tbc_pkg::kind_t     kd;
    if (it.func == tbc_pkg::FUNC_LOOKUP) begin
      s = slot_of(it.key);
      if (s < 0) begin
        lookup_misses = bump32(lookup_misses);
        push_status(tbc_pkg::KIND_MISS);
        return;
      end
      n = cache_size[s];
      if (n == 0 || n > BLK_BYTES) n = BLK_BYTES;
      cache_hits[s] = bump32(cache_hits[s]);
      lookup_hits   = bump32(lookup_hits);
      for (int k = 0; k < n; k++) begin
        r.kind        = tbc_pkg::KIND_HIT;
        r.out_byte    = cache_bytes[s*BLK_BYTES + k];
        r.block_size  = 7'(n);
        r.entry_hits  = cache_hits[s];
        r.stored_arch = cache_arch[s];
        r.hit_percent = hit_pct();
        r.run_last    = (k == n - 1);
        results_due.push_back(r);
        n_pushed++;
      end
      return;
    end
    if (stage_len < BLK_BYTES) begin
      stage_buf[stage_len] = it.data_byte;
      stage_len++;
    end else begin
      stage_ovf = 1'b1;
    end
    if (!it.last_byte) return;
    if (stage_ovf || stage_len == 0) begin
      kd = tbc_pkg::KIND_TOO_BIG;
    end else begin
      s = slot_of(it.key);
      if (s < 0 && slots_used >= SLOTS) begin
        kd = tbc_pkg::KIND_FULL;
      end else begin
        if (s < 0) begin
          s = slots_used;
          slots_used++;
          cache_hits[s] = '0;   // hit count kept on reinsert, zeroed on a new slot
        end
        for (int k = 0; k < stage_len; k++) cache_bytes[s*BLK_BYTES + k] = stage_buf[k];
        cache_key[s]  = it.key;
        cache_size[s] = 7'(stage_len);
        cache_arch[s] = it.arch_tag;
        kd = tbc_pkg::KIND_INS_OK;
      end
    end
    stage_len = 0;
    stage_ovf = 1'b0;
    push_status(kd);
  endfunction

  task automatic report(input string what);
    $display("[%0t] %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: strobe only, no back-pressure. Sampled at the edge ending the beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tbc_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result beat kind %0d", out_item.kind));
      end else begin
        e = results_due.pop_front();
        if (out_item.kind != e.kind)
          report($sformatf("kind %0d, want %0d", out_item.kind, e.kind));
        if (out_item.out_byte != e.out_byte)
          report($sformatf("out_byte %h, want %h", out_item.out_byte, e.out_byte));
        if (out_item.block_size != e.block_size)
          report($sformatf("block_size %0d, want %0d", out_item.block_size, e.block_size));
        if (out_item.entry_hits != e.entry_hits)
          report($sformatf("entry_hits %0d, want %0d", out_item.entry_hits, e.entry_hits));
        if (out_item.stored_arch != e.stored_arch)
          report($sformatf("stored_arch %h, want %h", out_item.stored_arch, e.stored_arch));
        if (out_item.hit_percent != e.hit_percent)
          report($sformatf("hit_percent %0d, want %0d", out_item.hit_percent, e.hit_percent));
        if (out_item.run_last != e.run_last)
          report($sformatf("run_last %0b, want %0b", out_item.run_last, e.run_last));
      end
    end
  end

  // Watchdog: generous bound over the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command side. A beat lands on the edge where start is high and busy low;
  // start is left high between back-to-back beats and only dropped for idles and drains.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input tbc_pkg::in_item_t it);
    if (idle_en && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_cache(it);
  endtask

  // Whole insert: n bytes under one key, last flagged only if the block ends here.
  task automatic send_block(input logic [31:0] k, input logic [7:0] tag, input int n,
                            input bit ends, input logic [7:0] seed, input bit rand_data);
    tbc_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.func      = tbc_pkg::FUNC_INSERT;
      it.key       = k;
      it.data_byte = rand_data ? 8'($urandom) : (seed ^ 8'(i * 29));
      it.arch_tag  = tag;
      it.last_byte = ends && (i == n - 1);
      send_beat(it);
    end
  endtask

  task automatic send_lookup(input logic [31:0] k);
    tbc_pkg::in_item_t it;
    it.func      = tbc_pkg::FUNC_LOOKUP;
    it.key       = k;
    it.data_byte = 8'($urandom);   // ignored, but toggled
    it.arch_tag  = 8'($urandom);
    it.last_byte = 1'($urandom);
    send_beat(it);
  endtask

  // Pause the sender until every outstanding result has drained.
  task automatic drain_pause();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  typedef struct {
    logic           func;
    logic [31:0]    key;
    logic [7:0]     arch;
    logic [7:0]     seed;
    int             nbytes;
    bit             ends;
    bit             typed;    // kind below written in by hand
    tbc_pkg::kind_t kind;
  } dir_row_t;

  dir_row_t    dir_tab[12];
  logic [31:0] key_pool[24];

  initial begin
    int       first;
    int       beats;
    int       n;
    int       pick;
    logic [31:0] k;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    cycles  = 0;
    mismatches    = 0;
    n_pushed      = 0;
    idle_en       = 1'b1;
    slots_used    = 0;
    stage_len     = 0;
    stage_ovf     = 1'b0;
    lookup_hits   = '0;
    lookup_misses = '0;

    // Directed: empty-table miss, extreme keys/sizes/tags, oversize reject,
    // reinsert keeping hit count, lookup in the middle of an insert.
    dir_tab = '{
      '{tbc_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'h00, 8'h00,  0, 1, 1, tbc_pkg::KIND_MISS},
      '{tbc_pkg::FUNC_INSERT, 32'h0000_0000, 8'h00, 8'hFF,  1, 1, 1, tbc_pkg::KIND_INS_OK},
      '{tbc_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'h00, 8'h00,  0, 1, 1, tbc_pkg::KIND_HIT},
      '{tbc_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hA5, 64, 1, 1, tbc_pkg::KIND_INS_OK},
      '{tbc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00, 8'h00,  0, 1, 1, tbc_pkg::KIND_HIT},
      '{tbc_pkg::FUNC_INSERT, 32'h0000_0001, 8'h11, 8'h3C, 65, 1, 1, tbc_pkg::KIND_TOO_BIG},
      '{tbc_pkg::FUNC_LOOKUP, 32'h0000_0001, 8'h00, 8'h00,  0, 1, 1, tbc_pkg::KIND_MISS},
      '{tbc_pkg::FUNC_INSERT, 32'h0000_0000, 8'h5A, 8'h00,  3, 1, 1, tbc_pkg::KIND_INS_OK},
      '{tbc_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'h00, 8'h00,  0, 1, 0, tbc_pkg::KIND_HIT},
      '{tbc_pkg::FUNC_INSERT, 32'h0000_0002, 8'h80, 8'h01,  2, 0, 0, tbc_pkg::KIND_INS_OK},
      '{tbc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00, 8'h00,  0, 1, 0, tbc_pkg::KIND_HIT},
      '{tbc_pkg::FUNC_INSERT, 32'h0000_0002, 8'h7F, 8'hFE,  1, 1, 1, tbc_pkg::KIND_INS_OK}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      first = n_pushed;
      if (dir_tab[i].func == tbc_pkg::FUNC_LOOKUP) send_lookup(dir_tab[i].key);
      else send_block(dir_tab[i].key, dir_tab[i].arch, dir_tab[i].nbytes,
                      dir_tab[i].ends, dir_tab[i].seed, 1'b0);
      // hand-written kind must agree with the predictor; a row's results share one kind
      if (dir_tab[i].typed && n_pushed > first &&
          results_due[$].kind != dir_tab[i].kind)
        report($sformatf("directed row %0d predicts kind %0d, table says %0d",
                         i, results_due[$].kind, dir_tab[i].kind));
    end

    drain_pause();

    // Random: a pool of keys so lookups hit; mostly small blocks, a few full
    // or oversize ones, and lookups slipped into the middle of inserts.
    foreach (key_pool[i]) key_pool[i] = $urandom;
    beats = 0;
    while (beats < RAND_BEATS) begin
      idle_en = !(beats >= 30 && beats < 65);   // a stretch with no idles
      if (beats >= 75 && beats < 80) drain_pause();
      pick = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? 32'($urandom) : key_pool[$urandom_range(0, 23)];
      if (pick < 50) begin
        send_lookup(k);
        beats++;
      end else begin
        case ($urandom_range(0, 19))
          0:       n = BLK_BYTES;
          1:       n = $urandom_range(BLK_BYTES + 1, BLK_BYTES + 3);
          default: n = $urandom_range(1, 8);
        endcase
        if (!(slot_of(k) < 0 && slots_used >= SLOTS - 2)) begin
          if (pick < 58 && n > 1) begin
            send_block(k, 8'($urandom), n / 2, 1'b0, 8'h00, 1'b1);
            send_lookup(key_pool[$urandom_range(0, 23)]);
            send_block(k, 8'($urandom), n - n / 2, 1'b1, 8'h00, 1'b1);
          end else begin
            send_block(k, 8'($urandom), n, 1'b1, 8'h00, 1'b1);
          end
          beats += n;
        end
      end
    end

    // Fill every slot with fresh keys, then one more insert must report full.
    drain_pause();
    idle_en = 1'b1;
    while (slots_used < SLOTS) begin
      k = $urandom;
      if (slot_of(k) < 0) send_block(k, 8'($urandom), 1, 1'b1, 8'h00, 1'b1);
    end
    do k = $urandom; while (slot_of(k) >= 0);
    send_block(k, 8'h42, 2, 1'b1, 8'h00, 1'b1);
    if (results_due[$].kind != tbc_pkg::KIND_FULL)
      report("full-table insert not predicted as full");
    send_lookup(k);

    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: translated_block_cache_top.f
+incdir+rtl
rtl/tbc_pkg.sv
rtl/tbc_cell.sv
rtl/tbc_pct_div.sv
rtl/translated_block_cache_top.sv
dv/translated_block_cache_top_tb.sv
